// File: rtl/ertm_pkg.sv
`timescale 1ns / 1ps
package ertm_pkg;

  // pipeline depths
  localparam int LANE_LAT  = 24;
  localparam int MERGE_LAT = 5;
  localparam int TOTAL_LAT = LANE_LAT + MERGE_LAT;

  localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;

  typedef logic signed [31:0] trig_t;

  typedef struct packed {
    trig_t s;
    trig_t c;
  } sincos_t;

  typedef enum logic [2:0] {
    ORD_XYZ, ORD_XZY, ORD_YXZ, ORD_YZX, ORD_ZXY, ORD_ZYX
  } rot_order_t;

  // unused order codes give the identity matrix
  localparam logic [2:0] ORD_UNUSED_A = 3'd6;
  localparam logic [2:0] ORD_UNUSED_B = 3'd7;

  typedef enum logic [2:0] {
    OP_ZERO, OP_ONE, OP_SX, OP_CX, OP_SY, OP_CY, OP_SZ, OP_CZ
  } op_sel_t;

  // one signed triple product a*b*c, evaluated left to right
  typedef struct packed {
    logic    neg;
    op_sel_t a;
    op_sel_t b;
    op_sel_t c;
  } term_t;

  typedef struct packed {
    term_t ta;
    term_t tb;
  } elem_spec_t;

  typedef elem_spec_t [8:0] mat_spec_t;

  localparam logic POS = 1'b0;
  localparam logic NEG = 1'b1;

  // series divisors and floor(2^32 / divisor)
  function automatic int sin_div(input int k);
    int d;
    d = (2 * k) * (2 * k + 1);
    return d;
  endfunction

  function automatic int cos_div(input int k);
    int d;
    d = (2 * k - 1) * (2 * k);
    return d;
  endfunction

  function automatic longint sin_recip(input int k);
    longint r;
    case (k)
      1: r = 64'd715827882;
      2: r = 64'd214748364;
      3: r = 64'd102261126;
      4: r = 64'd59652323;
      5: r = 64'd39045157;
      default: r = 64'd27531841;
    endcase
    return r;
  endfunction

  function automatic longint cos_recip(input int k);
    longint r;
    case (k)
      1: r = 64'd2147483648;
      2: r = 64'd357913941;
      3: r = 64'd143165576;
      4: r = 64'd76695844;
      5: r = 64'd47721858;
      default: r = 64'd32537631;
    endcase
    return r;
  endfunction

  function automatic term_t t3(input logic neg, input op_sel_t a, input op_sel_t b,
                               input op_sel_t c);
    term_t t;
    t.neg = neg;
    t.a = a;
    t.b = b;
    t.c = c;
    return t;
  endfunction

  function automatic term_t t2(input logic neg, input op_sel_t a, input op_sel_t b);
    return t3(neg, a, b, OP_ONE);
  endfunction

  function automatic term_t t1(input logic neg, input op_sel_t a);
    return t3(neg, a, OP_ONE, OP_ONE);
  endfunction

  // product formulas per rotation order; element slots are 0,1,2,4,5,6,8,9,10
  function automatic mat_spec_t mat_spec(input logic [2:0] order);
    mat_spec_t m;
    term_t     z;
    z = t1(POS, OP_ZERO);
    for (int i = 0; i < 9; i++) begin
      m[i].ta = z;
      m[i].tb = z;
    end
    case (order)
      ORD_XYZ: begin
        m[0] = '{t2(POS, OP_CY, OP_CZ), z};
        m[1] = '{t3(POS, OP_SX, OP_SY, OP_CZ), t2(POS, OP_CX, OP_SZ)};
        m[2] = '{t3(NEG, OP_CX, OP_SY, OP_CZ), t2(POS, OP_SX, OP_SZ)};
        m[3] = '{t2(NEG, OP_CY, OP_SZ), z};
        m[4] = '{t3(NEG, OP_SX, OP_SY, OP_SZ), t2(POS, OP_CX, OP_CZ)};
        m[5] = '{t3(POS, OP_CX, OP_SY, OP_SZ), t2(POS, OP_SX, OP_CZ)};
        m[6] = '{t1(POS, OP_SY), z};
        m[7] = '{t2(NEG, OP_SX, OP_CY), z};
        m[8] = '{t2(POS, OP_CX, OP_CY), z};
      end
      ORD_XZY: begin
        m[0] = '{t2(POS, OP_CZ, OP_CY), z};
        m[1] = '{t3(POS, OP_CX, OP_SZ, OP_CY), t2(POS, OP_SX, OP_SY)};
        m[2] = '{t3(POS, OP_SX, OP_SZ, OP_CY), t2(NEG, OP_CX, OP_SY)};
        m[3] = '{t1(NEG, OP_SZ), z};
        m[4] = '{t2(POS, OP_CX, OP_CZ), z};
        m[5] = '{t2(POS, OP_SX, OP_CZ), z};
        m[6] = '{t2(POS, OP_CZ, OP_SY), z};
        m[7] = '{t3(POS, OP_CX, OP_SZ, OP_SY), t2(NEG, OP_SX, OP_CY)};
        m[8] = '{t3(POS, OP_SX, OP_SZ, OP_SY), t2(POS, OP_CX, OP_CY)};
      end
      ORD_YXZ: begin
        m[0] = '{t2(POS, OP_CY, OP_CZ), t3(POS, OP_SY, OP_SX, OP_SZ)};
        m[1] = '{t2(POS, OP_CX, OP_SZ), z};
        m[2] = '{t2(NEG, OP_SY, OP_CZ), t3(POS, OP_CY, OP_SX, OP_SZ)};
        m[3] = '{t2(NEG, OP_CY, OP_SZ), t3(POS, OP_SY, OP_SX, OP_CZ)};
        m[4] = '{t2(POS, OP_CX, OP_CZ), z};
        m[5] = '{t2(POS, OP_SY, OP_SZ), t3(POS, OP_CY, OP_SX, OP_CZ)};
        m[6] = '{t2(POS, OP_SY, OP_CX), z};
        m[7] = '{t1(NEG, OP_SX), z};
        m[8] = '{t2(POS, OP_CY, OP_CX), z};
      end
      ORD_YZX: begin
        m[0] = '{t2(POS, OP_CY, OP_CZ), z};
        m[1] = '{t1(POS, OP_SZ), z};
        m[2] = '{t2(NEG, OP_SY, OP_CZ), z};
        m[3] = '{t3(NEG, OP_CY, OP_SZ, OP_CX), t2(POS, OP_SY, OP_SX)};
        m[4] = '{t2(POS, OP_CZ, OP_CX), z};
        m[5] = '{t3(POS, OP_SY, OP_SZ, OP_CX), t2(POS, OP_CY, OP_SX)};
        m[6] = '{t3(POS, OP_CY, OP_SZ, OP_SX), t2(POS, OP_SY, OP_CX)};
        m[7] = '{t2(NEG, OP_CZ, OP_SX), z};
        m[8] = '{t3(NEG, OP_SY, OP_SZ, OP_SX), t2(POS, OP_CY, OP_CX)};
      end
      ORD_ZXY: begin
        m[0] = '{t2(POS, OP_CZ, OP_CY), t3(NEG, OP_SZ, OP_SX, OP_SY)};
        m[1] = '{t2(POS, OP_SZ, OP_CY), t3(POS, OP_CZ, OP_SX, OP_SY)};
        m[2] = '{t2(NEG, OP_CX, OP_SY), z};
        m[3] = '{t2(NEG, OP_SZ, OP_CX), z};
        m[4] = '{t2(POS, OP_CZ, OP_CX), z};
        m[5] = '{t1(POS, OP_SX), z};
        m[6] = '{t2(POS, OP_CZ, OP_SY), t3(POS, OP_SZ, OP_SX, OP_CY)};
        m[7] = '{t2(POS, OP_SZ, OP_SY), t3(NEG, OP_CZ, OP_SX, OP_CY)};
        m[8] = '{t2(POS, OP_CX, OP_CY), z};
      end
      ORD_ZYX: begin
        m[0] = '{t2(POS, OP_CZ, OP_CY), z};
        m[1] = '{t2(POS, OP_SZ, OP_CY), z};
        m[2] = '{t1(NEG, OP_SY), z};
        m[3] = '{t2(NEG, OP_SZ, OP_CX), t3(POS, OP_CZ, OP_SY, OP_SX)};
        m[4] = '{t2(POS, OP_CZ, OP_CX), t3(POS, OP_SZ, OP_SY, OP_SX)};
        m[5] = '{t2(POS, OP_CY, OP_SX), z};
        m[6] = '{t2(POS, OP_SZ, OP_SX), t3(POS, OP_CZ, OP_SY, OP_CX)};
        m[7] = '{t2(NEG, OP_CZ, OP_SX), t3(POS, OP_SZ, OP_SY, OP_CX)};
        m[8] = '{t2(POS, OP_CY, OP_CX), z};
      end
      default: begin
        m[0] = '{t1(POS, OP_ONE), z};
        m[4] = '{t1(POS, OP_ONE), z};
        m[8] = '{t1(POS, OP_ONE), z};
      end
    endcase
    return m;
  endfunction

endpackage

// File: rtl/ertm_sincos.sv
`timescale 1ns / 1ps
module ertm_sincos (
  input  logic                clk,
  input  logic signed [31:0]  angle,
  output ertm_pkg::sincos_t   sc
);
  import ertm_pkg::*;

  typedef struct packed {
    logic signed [31:0] s;
    logic signed [31:0] c;
    logic [29:0]        x2;
    logic [1:0]         quad;
    logic               swap;
  } carry_t;

  // stage 1: reduce mod 360 deg = 45 * 2^19 (offset makes the value non-negative)
  logic [31:0] u;
  logic [32:0] w;
  logic [13:0] h;
  logic [24:0] qh_prod;
  logic [8:0]  qh;
  logic [13:0] qh45;
  logic [13:0] rh_full;
  logic [6:0]  rh_r;
  logic [18:0] lo_r;

  always_comb begin
    u       = {~angle[31], angle[30:0]};
    w       = {1'b0, u} + 33'd23068672;
    h       = w[32:19];
    qh_prod = 25'(h) * 25'd1456;
    qh      = qh_prod[24:16];
    qh45    = 14'({5'd0, qh} * 14'd45);
    rh_full = h - qh45;
  end

  always_ff @(posedge clk) begin
    rh_r <= rh_full[6:0];
    lo_r <= w[18:0];
  end

  // stage 2: quadrant and octant fold
  logic [6:0]  hm7;
  logic [7:0]  t8;
  logic [7:0]  rem8;
  logic [1:0]  quad;
  logic [22:0] r23;
  logic        swap;
  logic [22:0] rf;
  logic [21:0] r_r;
  logic [1:0]  quad2_r;
  logic        swap2_r;

  always_comb begin
    hm7 = (rh_r >= 7'd45) ? rh_r - 7'd45 : rh_r;
    t8  = {hm7[5:0], lo_r[18:17]};
    if (t8 >= 8'd135) begin
      quad = 2'd3;
      rem8 = t8 - 8'd135;
    end else if (t8 >= 8'd90) begin
      quad = 2'd2;
      rem8 = t8 - 8'd90;
    end else if (t8 >= 8'd45) begin
      quad = 2'd1;
      rem8 = t8 - 8'd45;
    end else begin
      quad = 2'd0;
      rem8 = t8;
    end
    r23  = {rem8[5:0], lo_r[16:0]};
    swap = r23 > 23'd2949120;
    rf   = swap ? 23'd5898240 - r23 : r23;
  end

  always_ff @(posedge clk) begin
    r_r     <= rf[21:0];
    quad2_r <= quad;
    swap2_r <= swap;
  end

  // stages 3-4: radians, x = r * round(pi/180 * 2^40) >> 26, split in two products
  logic [39:0] pl_r;
  logic [39:0] ph_r;
  logic [1:0]  quad3_r;
  logic        swap3_r;
  logic [57:0] xsum;
  logic [29:0] x_r;
  logic [1:0]  quad4_r;
  logic        swap4_r;

  always_ff @(posedge clk) begin
    pl_r    <= 40'(r_r) * 40'd108693;
    ph_r    <= 40'(r_r) * 40'd73204;
    quad3_r <= quad2_r;
    swap3_r <= swap2_r;
  end

  assign xsum = {ph_r[39:0], 18'd0} + {18'd0, pl_r};

  always_ff @(posedge clk) begin
    x_r     <= xsum[55:26];
    quad4_r <= quad3_r;
    swap4_r <= swap3_r;
  end

  // stage 5: x^2 and series seeds
  logic [59:0] sq;
  logic [29:0] ts_r [0:6];
  logic [29:0] tc_r [0:6];
  carry_t      cy_r [0:6];

  assign sq = 60'(x_r) * 60'(x_r);

  always_ff @(posedge clk) begin
    ts_r[0]      <= x_r;
    tc_r[0]      <= 30'd0;
    cy_r[0].s    <= 32'(x_r);
    cy_r[0].c    <= ONE_Q30;
    cy_r[0].x2   <= sq[59:30];
    cy_r[0].quad <= quad4_r;
    cy_r[0].swap <= swap4_r;
  end

  // six series terms, three stages each: multiply by x^2, reciprocal, correct and add
  for (genvar k = 1; k <= 6; k++) begin : g_term
    localparam logic [29:0] SD = 30'(sin_div(k));
    localparam logic [29:0] CD = 30'(cos_div(k));
    localparam logic [31:0] SM = 32'(sin_recip(k));
    localparam logic [31:0] CM = 32'(cos_recip(k));

    logic [59:0] prod_s;
    logic [60:0] prod_c;
    logic [29:0] tc_prev;
    logic [29:0] pa_s_r, pa_c_r;
    carry_t      ca_r;
    logic [61:0] rq_s, rq_c;
    logic [29:0] pb_s_r, pb_c_r, qb_s_r, qb_c_r;
    carry_t      cb_r;
    logic [29:0] rem_s, rem_c, qs, qc;

    // first cosine term starts from 1.0, which does not fit the term register
    assign tc_prev = tc_r[k-1];
    assign prod_s  = 60'(ts_r[k-1]) * 60'(cy_r[k-1].x2);
    assign prod_c  = (k == 1) ? {1'b0, cy_r[k-1].x2, 30'd0}
                              : 61'(tc_prev) * 61'(cy_r[k-1].x2);

    always_ff @(posedge clk) begin
      pa_s_r <= prod_s[59:30];
      pa_c_r <= prod_c[59:30];
      ca_r   <= cy_r[k-1];
    end

    assign rq_s = 62'(pa_s_r) * 62'(SM);
    assign rq_c = 62'(pa_c_r) * 62'(CM);

    always_ff @(posedge clk) begin
      pb_s_r <= pa_s_r;
      pb_c_r <= pa_c_r;
      qb_s_r <= rq_s[61:32];
      qb_c_r <= rq_c[61:32];
      cb_r   <= ca_r;
    end

    always_comb begin
      rem_s = pb_s_r - 30'(qb_s_r * SD);
      rem_c = pb_c_r - 30'(qb_c_r * CD);
      qs    = (rem_s >= SD) ? qb_s_r + 30'd1 : qb_s_r;
      qc    = (rem_c >= CD) ? qb_c_r + 30'd1 : qb_c_r;
    end

    always_ff @(posedge clk) begin
      ts_r[k]      <= qs;
      tc_r[k]      <= qc;
      cy_r[k].x2   <= cb_r.x2;
      cy_r[k].quad <= cb_r.quad;
      cy_r[k].swap <= cb_r.swap;
      if (k % 2 == 1) begin
        cy_r[k].s <= cb_r.s - 32'(qs);
        cy_r[k].c <= cb_r.c - 32'(qc);
      end else begin
        cy_r[k].s <= cb_r.s + 32'(qs);
        cy_r[k].c <= cb_r.c + 32'(qc);
      end
    end
  end

  // unfold octant and quadrant
  trig_t   s_f, c_f;
  sincos_t sc_nxt;
  sincos_t sc_r;

  always_comb begin
    s_f = cy_r[6].swap ? cy_r[6].c : cy_r[6].s;
    c_f = cy_r[6].swap ? cy_r[6].s : cy_r[6].c;
    case (cy_r[6].quad)
      2'd0: begin
        sc_nxt.s = s_f;
        sc_nxt.c = c_f;
      end
      2'd1: begin
        sc_nxt.s = c_f;
        sc_nxt.c = -s_f;
      end
      2'd2: begin
        sc_nxt.s = -s_f;
        sc_nxt.c = -c_f;
      end
      default: begin
        sc_nxt.s = -c_f;
        sc_nxt.c = s_f;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    sc_r <= sc_nxt;
  end

  assign sc = sc_r;

endmodule

// File: rtl/ertm_merge.sv
`timescale 1ns / 1ps
module ertm_merge #(
  parameter int OUT_FRAC_BITS = 16,
  localparam int OUT_W = OUT_FRAC_BITS + 2
) (
  input  logic                    clk,
  input  ertm_pkg::sincos_t       sc_x,
  input  ertm_pkg::sincos_t       sc_y,
  input  ertm_pkg::sincos_t       sc_z,
  input  logic [2:0]              order,
  output logic signed [OUT_W-1:0] elem [9]
);
  import ertm_pkg::*;

  localparam int          SH  = 30 - OUT_FRAC_BITS;
  localparam logic [35:0] RND = (SH > 0) ? (36'd1 << (SH - 1)) : 36'd0;
  localparam logic [35:0] LIM = 36'd1 << OUT_FRAC_BITS;

  // Q30 product, magnitude truncated then signed
  function automatic logic signed [33:0] qmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic [31:0] ma, mb;
    logic [63:0] pr;
    logic [33:0] m;
    ma = a[31] ? 32'(-a) : 32'(a);
    mb = b[31] ? 32'(-b) : 32'(b);
    pr = 64'(ma) * 64'(mb);
    m  = pr[63:30];
    return (a[31] ^ b[31]) ? -$signed(m) : $signed(m);
  endfunction

  function automatic trig_t pick(input op_sel_t op, input sincos_t x, input sincos_t y,
                                 input sincos_t z);
    trig_t v;
    case (op)
      OP_ZERO: v = '0;
      OP_ONE:  v = ONE_Q30;
      OP_SX:   v = x.s;
      OP_CX:   v = x.c;
      OP_SY:   v = y.s;
      OP_CY:   v = y.c;
      OP_SZ:   v = z.s;
      OP_CZ:   v = z.c;
      default: v = '0;
    endcase
    return v;
  endfunction

  mat_spec_t spec;
  assign spec = mat_spec(order);

  trig_t              opa_r [9][2];
  trig_t              opb_r [9][2];
  trig_t              opc_r [9][2];
  logic               neg_r [9][2];
  logic signed [33:0] p1_r  [9][2];
  trig_t              opc1_r[9][2];
  logic               neg1_r[9][2];
  logic signed [33:0] p2_r  [9][2];
  logic signed [34:0] sum_r [9];
  logic signed [OUT_W-1:0] elem_r [9];

  for (genvar e = 0; e < 9; e++) begin : g_elem
    for (genvar t = 0; t < 2; t++) begin : g_term
      term_t tm;
      logic signed [33:0] p2;
      assign tm = (t == 0) ? spec[e].ta : spec[e].tb;
      assign p2 = qmul(32'(p1_r[e][t]), opc1_r[e][t]);

      always_ff @(posedge clk) begin
        opa_r[e][t]  <= pick(tm.a, sc_x, sc_y, sc_z);
        opb_r[e][t]  <= pick(tm.b, sc_x, sc_y, sc_z);
        opc_r[e][t]  <= pick(tm.c, sc_x, sc_y, sc_z);
        neg_r[e][t]  <= tm.neg;
        p1_r[e][t]   <= qmul(opa_r[e][t], opb_r[e][t]);
        opc1_r[e][t] <= opc_r[e][t];
        neg1_r[e][t] <= neg_r[e][t];
        p2_r[e][t]   <= neg1_r[e][t] ? -p2 : p2;
      end
    end

    logic [35:0] mag, rnd;
    logic [35:0] sat;
    logic [35:0] sgn;

    always_comb begin
      mag = sum_r[e][34] ? 36'(-sum_r[e]) : 36'(sum_r[e]);
      rnd = (mag + RND) >> SH;
      sat = (rnd > LIM) ? LIM : rnd;
      sgn = sum_r[e][34] ? -sat : sat;
    end

    always_ff @(posedge clk) begin
      sum_r[e]  <= 35'(p2_r[e][0]) + 35'(p2_r[e][1]);
      elem_r[e] <= sgn[OUT_W-1:0];
    end

    assign elem[e] = elem_r[e];
  end

endmodule

// File: rtl/euler_to_rotation_matrix.sv
`timescale 1ns / 1ps
// Euler angles (signed Q15.16 degrees) and a rotation order code in, the nine
// 3x3 rotation-matrix elements (signed, OUT_FRAC_BITS fraction bits, clamped to
// +/-1.0) out. One transaction is taken every cycle; busy stays low. Each result
// appears on out_valid after it has passed the three per-axis sine/cosine lanes
// (reduction, radian scaling, six series terms of three stages each) and then
// the matrix product stage. The receiver must take every result in the cycle it
// is shown.
module euler_to_rotation_matrix #(
  parameter int OUT_FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [31:0]              in_angle_x,
  input  logic signed [31:0]              in_angle_y,
  input  logic signed [31:0]              in_angle_z,
  input  logic [2:0]                      in_rotation_order,
  output logic                            out_valid,
  output logic signed [OUT_FRAC_BITS+1:0] out_elem_0,
  output logic signed [OUT_FRAC_BITS+1:0] out_elem_1,
  output logic signed [OUT_FRAC_BITS+1:0] out_elem_2,
  output logic signed [OUT_FRAC_BITS+1:0] out_elem_4,
  output logic signed [OUT_FRAC_BITS+1:0] out_elem_5,
  output logic signed [OUT_FRAC_BITS+1:0] out_elem_6,
  output logic signed [OUT_FRAC_BITS+1:0] out_elem_8,
  output logic signed [OUT_FRAC_BITS+1:0] out_elem_9,
  output logic signed [OUT_FRAC_BITS+1:0] out_elem_10
);
  import ertm_pkg::*;

  localparam int OUT_W = OUT_FRAC_BITS + 2;

  sincos_t                 sc_x, sc_y, sc_z;
  logic [2:0]              ord_r [LANE_LAT];
  logic [TOTAL_LAT-1:0]    vld_r;
  logic signed [OUT_W-1:0] elem [9];

  assign busy = 1'b0;

  ertm_sincos u_lane_x (.clk(clk), .angle(in_angle_x), .sc(sc_x));
  ertm_sincos u_lane_y (.clk(clk), .angle(in_angle_y), .sc(sc_y));
  ertm_sincos u_lane_z (.clk(clk), .angle(in_angle_z), .sc(sc_z));

  // order code travels alongside the lanes
  always_ff @(posedge clk) begin
    ord_r[0] <= in_rotation_order;
    for (int i = 1; i < LANE_LAT; i++) begin
      ord_r[i] <= ord_r[i-1];
    end
  end

  ertm_merge #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_merge (
    .clk  (clk),
    .sc_x (sc_x),
    .sc_y (sc_y),
    .sc_z (sc_z),
    .order(ord_r[LANE_LAT-1]),
    .elem (elem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[TOTAL_LAT-2:0], start & ~busy};
    end
  end

  assign out_valid   = vld_r[TOTAL_LAT-1];
  assign out_elem_0  = elem[0];
  assign out_elem_1  = elem[1];
  assign out_elem_2  = elem[2];
  assign out_elem_4  = elem[3];
  assign out_elem_5  = elem[4];
  assign out_elem_6  = elem[5];
  assign out_elem_8  = elem[6];
  assign out_elem_9  = elem[7];
  assign out_elem_10 = elem[8];

endmodule

// File: rtl/ertm_checker.sv
`timescale 1ns / 1ps
module ertm_checker #(
  parameter int OUT_FRAC_BITS = 16
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            start,
  input logic                            busy,
  input logic [2:0]                      in_rotation_order,
  input logic                            out_valid,
  input logic signed [OUT_FRAC_BITS+1:0] out_elem_0,
  input logic signed [OUT_FRAC_BITS+1:0] out_elem_1,
  input logic signed [OUT_FRAC_BITS+1:0] out_elem_5,
  input logic signed [OUT_FRAC_BITS+1:0] out_elem_10
);
  import ertm_pkg::*;

  localparam int LIM = 1 << OUT_FRAC_BITS;
  localparam logic signed [OUT_FRAC_BITS+1:0] P1 = (OUT_FRAC_BITS + 2)'(LIM);
  localparam logic signed [OUT_FRAC_BITS+1:0] N1 = -P1;

  logic in_range;
  assign in_range = (out_elem_0 <= P1) && (out_elem_0 >= N1) &&
                    (out_elem_1 <= P1) && (out_elem_1 >= N1) &&
                    (out_elem_5 <= P1) && (out_elem_5 >= N1) &&
                    (out_elem_10 <= P1) && (out_elem_10 >= N1);

  a_every_start_answered: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##TOTAL_LAT out_valid)
    else $error("accepted transaction produced no result");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, TOTAL_LAT))
    else $error("result without a matching transaction");

  a_identity_unused: assert property (@(posedge clk) disable iff (!rst_n)
    start && (in_rotation_order == ORD_UNUSED_A || in_rotation_order == ORD_UNUSED_B)
    |-> ##TOTAL_LAT (out_elem_0 == P1 && out_elem_1 == '0 && out_elem_5 == P1 &&
                     out_elem_10 == P1))
    else $error("unused order code did not give identity");

  a_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_range)
    else $error("matrix element beyond +/-1.0");

endmodule

bind euler_to_rotation_matrix ertm_checker #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_ertm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_rotation_order(in_rotation_order),
  .out_valid        (out_valid),
  .out_elem_0       (out_elem_0),
  .out_elem_1       (out_elem_1),
  .out_elem_5       (out_elem_5),
  .out_elem_10      (out_elem_10)
);
